### rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/swcrc_pkg.sv
// Package: word types, CRC-8 constants and the byte-wise CRC update.
package swcrc_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_TOPBIT = 8'h80;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_WORD1_BAD = 2'd1;
    localparam logic [1:0] STATUS_WORD2_BAD = 2'd2;
    localparam logic [1:0] STATUS_UNUSED    = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] co2_value;
        logic [15:0] tvoc_value;
    } out_word_t;

    // Advance the CRC by one byte, MSB first.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((r & CRC_TOPBIT) != 8'h00)
            begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

### rtl/swcrc_in_stage.sv
// Input register stage: capture one byte word per handshake.
module swcrc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  swcrc_pkg::in_word_t byte_data,
    input  logic                take,
    output logic                stage_valid,
    output swcrc_pkg::in_word_t stage_word
);

    logic                valid_reg;
    logic                valid_next;
    swcrc_pkg::in_word_t word_reg;
    logic                accept;

    assign byte_stall = valid_reg && !take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= byte_data;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_word  = word_reg;

endmodule

### rtl/swcrc_frame.sv
// Frame stage: byte position, CRC check, reading latches and result register.
module swcrc_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stage_valid,
    input  swcrc_pkg::in_word_t  stage_word,
    output logic                 take,
    output logic                 result_valid,
    input  logic                 result_stall,
    output swcrc_pkg::out_word_t result_data
);

    localparam logic [2:0] POS_W1_HI  = 3'd0;
    localparam logic [2:0] POS_W1_LO  = 3'd1;
    localparam logic [2:0] POS_W1_CRC = 3'd2;
    localparam logic [2:0] POS_W2_HI  = 3'd3;
    localparam logic [2:0] POS_W2_LO  = 3'd4;
    localparam logic [2:0] POS_W2_CRC = 3'd5;

    logic [2:0]  pos_reg,   pos_next;
    logic [7:0]  crc_reg,   crc_next;
    logic [15:0] pend1_reg, pend1_next;
    logic [15:0] pend2_reg, pend2_next;
    logic        fail_reg,  fail_next;
    logic [15:0] co2_reg,   co2_next;
    logic [15:0] tvoc_reg,  tvoc_next;
    logic        out_valid_reg, out_valid_next;
    swcrc_pkg::out_word_t out_word_reg;
    swcrc_pkg::out_word_t out_word_next;

    logic [2:0] pos_eff;
    logic [7:0] crc_base;
    logic [7:0] crc_upd;
    logic [7:0] b;
    logic       emit;

    assign b        = stage_word.rx_byte;
    assign pos_eff  = (stage_word.frame_start || pos_reg > POS_W2_CRC) ? POS_W1_HI : pos_reg;
    assign crc_base = (pos_eff == POS_W1_HI) ? swcrc_pkg::CRC_INIT : crc_reg;
    assign crc_upd  = swcrc_pkg::crc_byte(crc_base, b);
    assign emit     = (pos_eff == POS_W2_CRC);
    assign take     = stage_valid && (!emit || !out_valid_reg || !result_stall);

    always_comb
    begin
        crc_next      = crc_upd;
        pend1_next    = pend1_reg;
        pend2_next    = pend2_reg;
        fail_next     = fail_reg;
        co2_next      = co2_reg;
        tvoc_next     = tvoc_reg;
        out_word_next = out_word_reg;
        unique case (pos_eff)
            POS_W1_HI:  pend1_next = {b, 8'h00};
            POS_W1_LO:  pend1_next = {pend1_reg[15:8], b};
            POS_W1_CRC:
            begin
                fail_next = (crc_base != b);
                crc_next  = swcrc_pkg::CRC_INIT;
            end
            POS_W2_HI:  pend2_next = {b, 8'h00};
            POS_W2_LO:  pend2_next = {pend2_reg[15:8], b};
            default:
            begin
                crc_next = swcrc_pkg::CRC_INIT;
                priority if (fail_reg)
                begin
                    out_word_next.status = swcrc_pkg::STATUS_WORD1_BAD;
                end
                else if (crc_base != b)
                begin
                    out_word_next.status = swcrc_pkg::STATUS_WORD2_BAD;
                end
                else
                begin
                    out_word_next.status = swcrc_pkg::STATUS_OK;
                    co2_next  = pend1_reg;
                    tvoc_next = pend2_reg;
                end
                out_word_next.co2_value  = co2_next;
                out_word_next.tvoc_value = tvoc_next;
            end
        endcase
        pos_next = (pos_eff == POS_W2_CRC) ? POS_W1_HI : pos_eff + 3'd1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_W1_HI;
            crc_reg       <= swcrc_pkg::CRC_INIT;
            fail_reg      <= 1'b0;
            co2_reg       <= 16'h0000;
            tvoc_reg      <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pos_reg  <= pos_next;
                crc_reg  <= crc_next;
                fail_reg <= fail_next;
                co2_reg  <= co2_next;
                tvoc_reg <= tvoc_next;
            end
        end
    end

    // Pending words and the result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend1_reg <= pend1_next;
            pend2_reg <= pend2_next;
        end
        if (take && emit)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_word_reg;

endmodule

### rtl/sensor_word_crc_frame_checker_top.sv
// A byte passes the input stage register, then the result register, before its result shows.
// Throughput: one byte word per cycle while no result word stalls (combinational CRC-8 update).
// One result word per six-byte frame, on its last byte; other bytes emit nothing.
// Reset (rst_n low, asynchronous): position 0, CRC 0xFF, readings 0, no words held.
// Pending words and result payload are not reset.
`include "assert_macros.svh"

module sensor_word_crc_frame_checker_top (
    input  logic                 clk,
    input  logic                 rst_n,
    // Byte channel.
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  swcrc_pkg::in_word_t  byte_data,
    // Result channel.
    output logic                 result_valid,
    input  logic                 result_stall,
    output swcrc_pkg::out_word_t result_data
);

    logic                stage_valid;
    swcrc_pkg::in_word_t stage_word;
    logic                take;

    // Hold the accepted byte; release it once the frame stage takes it.
    swcrc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_word  (stage_word)
    );

    // Advance the frame position, check each word's CRC and drive the result register.
    // A byte that emits nothing always advances; the last byte waits only
    // while a previous result word is still stalled.
    swcrc_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid),
        .stage_word   (stage_word),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Back-pressure on the byte side only arises from a stalled result word.
    `ASSERT_SAME(a_stall_from_result, clk, rst_n, byte_stall, result_valid && result_stall)
    // A stall always has a byte held in the input stage.
    `ASSERT_SAME(a_stall_has_item, clk, rst_n, byte_stall, stage_valid)
    // Status never carries the unused code.
    `ASSERT_SAME(a_status_code, clk, rst_n, result_valid, result_data.status != swcrc_pkg::STATUS_UNUSED)
    // A held byte that is not taken stays in the stage.
    `ASSERT_NEXT(a_hold_item, clk, rst_n, stage_valid && !take, stage_valid)

endmodule

### tb/sensor_word_crc_frame_checker_top_tb.sv
// Self-checking testbench for the sensor word CRC frame checker top level.
`timescale 1ns / 1ps

module sensor_word_crc_frame_checker_top_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    // Two register stages inside the block; allow some slack after the last result.
    localparam int DRAIN_CYCLES   = 10;
    // Cycles with no word moving on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 500;

    // Byte positions within one six-byte measurement frame.
    localparam logic [2:0] POS_CO2_HI   = 3'd0;
    localparam logic [2:0] POS_CO2_LO   = 3'd1;
    localparam logic [2:0] POS_CO2_CRC  = 3'd2;
    localparam logic [2:0] POS_TVOC_HI  = 3'd3;
    localparam logic [2:0] POS_TVOC_LO  = 3'd4;
    localparam logic [2:0] POS_TVOC_CRC = 3'd5;

    logic                 clk;
    logic                 rst_n;
    logic                 byte_valid;
    logic                 byte_stall;
    swcrc_pkg::in_word_t  byte_data;
    logic                 result_valid;
    logic                 result_stall;
    swcrc_pkg::out_word_t result_data;

    // Expected result words, oldest first.
    swcrc_pkg::out_word_t expected_readings[$];
    swcrc_pkg::out_word_t want;

    // Shadow copy of the frame checker state.
    logic [2:0]  frame_pos;
    logic [7:0]  frame_crc;
    logic [15:0] held_co2_word;
    logic [15:0] held_tvoc_word;
    logic        co2_word_bad;
    logic [15:0] good_co2;
    logic [15:0] good_tvoc;

    // Traffic shaping knobs, set per test.
    int sender_idle_pct;
    int receiver_stall_pct;

    // Bookkeeping.
    int error_count;
    int bytes_sent;
    int frames_checked;
    int frames_ok;
    int frames_co2_bad;
    int frames_tvoc_bad;
    int idle_cycles;

    sensor_word_crc_frame_checker_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // 10 ns clock, high then low.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Advance a CRC-8 (poly 0x31, MSB first) by one byte, one bit at a time.
    function automatic logic [7:0] crc_shift_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       feedback;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (feedback ? swcrc_pkg::CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    // CRC byte that the sensor appends to one big-endian word.
    function automatic logic [7:0] word_crc(input logic [15:0] word);
        return crc_shift_byte(crc_shift_byte(swcrc_pkg::CRC_INIT, word[15:8]), word[7:0]);
    endfunction

    // Update the shadow state with one accepted byte; queue a result on the sixth byte.
    function automatic void predict_frame_byte(input swcrc_pkg::in_word_t w);
        logic [2:0]           pos;
        swcrc_pkg::out_word_t r;
        pos = (w.frame_start || frame_pos > POS_TVOC_CRC) ? POS_CO2_HI : frame_pos;
        // A frame start mid-frame drops the partial frame and restarts the CRC.
        if (pos == POS_CO2_HI)
        begin
            frame_crc = swcrc_pkg::CRC_INIT;
        end
        case (pos)
            POS_CO2_HI:
            begin
                held_co2_word = {w.rx_byte, 8'h00};
                frame_crc     = crc_shift_byte(frame_crc, w.rx_byte);
            end
            POS_CO2_LO:
            begin
                held_co2_word[7:0] = w.rx_byte;
                frame_crc          = crc_shift_byte(frame_crc, w.rx_byte);
            end
            POS_CO2_CRC:
            begin
                co2_word_bad = (frame_crc != w.rx_byte);
                frame_crc    = swcrc_pkg::CRC_INIT;
            end
            POS_TVOC_HI:
            begin
                held_tvoc_word = {w.rx_byte, 8'h00};
                frame_crc      = crc_shift_byte(frame_crc, w.rx_byte);
            end
            POS_TVOC_LO:
            begin
                held_tvoc_word[7:0] = w.rx_byte;
                frame_crc           = crc_shift_byte(frame_crc, w.rx_byte);
            end
            default:
            begin
                // The first word is judged first; readings latch only on a clean frame.
                if (co2_word_bad)
                begin
                    r.status = swcrc_pkg::STATUS_WORD1_BAD;
                    frames_co2_bad++;
                end
                else if (frame_crc != w.rx_byte)
                begin
                    r.status = swcrc_pkg::STATUS_WORD2_BAD;
                    frames_tvoc_bad++;
                end
                else
                begin
                    r.status  = swcrc_pkg::STATUS_OK;
                    good_co2  = held_co2_word;
                    good_tvoc = held_tvoc_word;
                    frames_ok++;
                end
                r.co2_value  = good_co2;
                r.tvoc_value = good_tvoc;
                expected_readings.push_back(r);
                frame_crc = swcrc_pkg::CRC_INIT;
            end
        endcase
        // Wrap after the sixth byte so the next byte opens a new frame.
        frame_pos = (pos == POS_TVOC_CRC) ? POS_CO2_HI : pos + 3'd1;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        $display("MISMATCH at %0t, result %0d, %s: got %h, expected %h",
                 $realtime, frames_checked, field, got, exp_val);
        error_count++;
    endtask

    // Send one byte word: insert random idle cycles, then hold the word until accepted.
    task automatic send_byte(input logic [7:0] value, input logic mark);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid            = 1'b1;
        byte_data.rx_byte     = value;
        byte_data.frame_start = mark;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        predict_frame_byte(byte_data);
        bytes_sent++;
    endtask

    // Send one full frame; optionally corrupt either CRC byte and mark byte 0.
    task automatic send_frame(input logic [15:0] co2, input logic [15:0] tvoc,
                              input bit bad_co2, input bit bad_tvoc, input bit mark);
        logic [7:0] crc_a;
        logic [7:0] crc_b;
        crc_a = word_crc(co2);
        crc_b = word_crc(tvoc);
        if (bad_co2)
        begin
            crc_a = crc_a ^ 8'($urandom_range(255, 1));
        end
        if (bad_tvoc)
        begin
            crc_b = crc_b ^ 8'($urandom_range(255, 1));
        end
        send_byte(co2[15:8], mark);
        send_byte(co2[7:0], 1'b0);
        send_byte(crc_a, 1'b0);
        send_byte(tvoc[15:8], 1'b0);
        send_byte(tvoc[7:0], 1'b0);
        send_byte(crc_b, 1'b0);
    endtask

    // Drop valid and hold the sender until every expected result has arrived.
    task automatic wait_until_drained();
        @(negedge clk);
        byte_valid = 1'b0;
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random word with a bias toward the extremes.
    function automatic logic [15:0] pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
        begin
            return 16'h0000;
        end
        else if (sel < 10)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(65535));
    endfunction

    // Mostly well-formed frames with random content, plus truncated frames and noise.
    task automatic run_random_traffic(input int idle_pct, input int stall_pct,
                                      input int byte_budget, input bit pause_midway);
        int  start_count;
        int  kind;
        int  cut;
        bit  paused;
        start_count        = bytes_sent;
        paused             = 1'b0;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        while (bytes_sent - start_count < byte_budget)
        begin
            kind = $urandom_range(99);
            if (kind < 75)
            begin
                send_frame(pick_word(), pick_word(), $urandom_range(99) < 12,
                           $urandom_range(99) < 12, $urandom_range(99) < 70);
            end
            else if (kind < 88)
            begin
                // Truncated frame: the next marked byte throws it away.
                cut = $urandom_range(5, 1);
                send_byte(8'($urandom_range(255)), 1'b1);
                for (int i = 1; i < cut; i++)
                begin
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
                end
            end
            else
            begin
                send_byte(8'($urandom_range(255)), $urandom_range(99) < 15);
            end
            if (pause_midway && !paused && (bytes_sent - start_count) >= byte_budget / 2)
            begin
                wait_until_drained();
                paused = 1'b1;
            end
        end
        wait_until_drained();
    endtask

    // Directed frames: extremes, both failure kinds, resync and wrap without a marker.
    task automatic test_directed_frames();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // First frame straight after reset, no marker: position starts at zero.
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        // Back-to-back frame without a marker: position wraps.
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        // Both CRCs bad: first word wins, readings repeat.
        send_frame(16'h8001, 16'h7FFE, 1'b1, 1'b1, 1'b1);
        // Partial frame, then a marked restart with a bad second word.
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_frame(16'hBEEF, 16'h0001, 1'b0, 1'b1, 1'b1);
        wait_until_drained();
    endtask

    task automatic test_streaming_no_idle();
        run_random_traffic(0, 0, PHASE_BYTES, 1'b0);
    endtask

    task automatic test_sender_gaps();
        run_random_traffic(47, 0, PHASE_BYTES, 1'b1);
    endtask

    task automatic test_receiver_stalls();
        run_random_traffic(0, 47, PHASE_BYTES, 1'b0);
    endtask

    task automatic test_both_idle();
        run_random_traffic(20, 20, PHASE_BYTES, 1'b1);
    endtask

    // Receiver: raise stall at random, at the falling edge.
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                report_mismatch("unexpected result", 16'(result_data.status), 16'h0000);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (result_data.status !== want.status)
                begin
                    report_mismatch("status", 16'(result_data.status), 16'(want.status));
                end
                if (result_data.co2_value !== want.co2_value)
                begin
                    report_mismatch("co2_value", result_data.co2_value, want.co2_value);
                end
                if (result_data.tvoc_value !== want.tvoc_value)
                begin
                    report_mismatch("tvoc_value", result_data.tvoc_value, want.tvoc_value);
                end
            end
            frames_checked++;
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_readings.size());
            $display("** sensor_word_crc_frame_checker_top: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        // Drive every input to a known value from time zero.
        clk                = 1'b0;
        rst_n              = 1'b0;
        byte_valid         = 1'b0;
        byte_data          = '0;
        result_stall       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        bytes_sent         = 0;
        frames_checked     = 0;
        frames_ok          = 0;
        frames_co2_bad     = 0;
        frames_tvoc_bad    = 0;
        idle_cycles        = 0;

        // Shadow state matches the block after reset.
        frame_pos      = POS_CO2_HI;
        frame_crc      = swcrc_pkg::CRC_INIT;
        held_co2_word  = 16'h0000;
        held_tvoc_word = 16'h0000;
        co2_word_bad   = 1'b0;
        good_co2       = 16'h0000;
        good_tvoc      = 16'h0000;

        // Hold reset, then release it away from the rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_streaming_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        $display("Covered %0d bytes under no idling, sender gaps, receiver stalls and both",
                 bytes_sent);
        $display("Checked %0d frames: %0d good, %0d first word bad, %0d second word bad",
                 frames_checked, frames_ok, frames_co2_bad, frames_tvoc_bad);
        if (error_count == 0 && expected_readings.size() == 0)
        begin
            $display("** sensor_word_crc_frame_checker_top: PASSED **");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     error_count, expected_readings.size());
            $display("** sensor_word_crc_frame_checker_top: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/swcrc_pkg.sv
rtl/swcrc_in_stage.sv
rtl/swcrc_frame.sv
rtl/sensor_word_crc_frame_checker_top.sv
tb/sensor_word_crc_frame_checker_top_tb.sv
